>>> sv/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, reset values and control types of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned MOD_W        = 31;
  localparam int unsigned BASE_W       = 32;
  localparam int unsigned EXP_IN_W     = 32;
  localparam int unsigned PROD_W       = 2 * MOD_W;
  localparam int unsigned RED_CNT_W    = $clog2(PROD_W);
  localparam int unsigned EXP_BITS_DEF = 32;

  localparam logic [MOD_W-1:0] MOD_RESET = {MOD_W{1'b1}};

  // operation of the shared multiply / reduce unit
  typedef enum logic {
    OP_MUL = 1'b0,   // reduce a * b
    OP_RED = 1'b1    // reduce x
  } mexp_op_e;

  typedef struct packed {
    logic     start;
    mexp_op_e op;
  } mexp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mexp_stat_t;

endpackage

>>> sv/mexp_mulred.sv
// ----------------------------------------------------------------------------
// mexp_mulred
// Shared modular multiply / reduce unit: one registered 31x31 product (or x),
// then a bit-serial restoring remainder over the 62-bit value, one bit a cycle.
// ----------------------------------------------------------------------------
module mexp_mulred (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mexp_pkg::mexp_req_t       req_i,
  input  logic [mexp_pkg::MOD_W-1:0]  a_i,
  input  logic [mexp_pkg::MOD_W-1:0]  b_i,
  input  logic [mexp_pkg::BASE_W-1:0] x_i,
  input  logic [mexp_pkg::MOD_W-1:0]  mod_i,
  output mexp_pkg::mexp_stat_t      stat_o,
  output logic [mexp_pkg::MOD_W-1:0]  result_o
);
  import mexp_pkg::*;

  typedef enum logic [1:0] {
    U_IDLE = 2'b01,
    U_RED  = 2'b10
  } unit_state_e;

  unit_state_e          state_q, state_d;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [MOD_W-1:0]     rem_q, rem_d;

  logic [MOD_W:0]       trial;
  logic [MOD_W:0]       diff;
  logic [MOD_W-1:0]     rem_step;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_q, prod_q[PROD_W-1]};
    diff     = trial - {1'b0, mod_i};
    rem_step = (trial >= {1'b0, mod_i}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prod_d  = prod_q;
    rem_d   = rem_q;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_MUL) begin
            prod_d = PROD_W'(a_i) * PROD_W'(b_i);
          end else begin
            prod_d = PROD_W'(x_i);
          end
          rem_d   = '0;
          cnt_d   = RED_CNT_W'(PROD_W - 1);
          state_d = U_RED;
        end
      end
      U_RED: begin
        rem_d  = rem_step;
        prod_d = prod_q << 1;
        cnt_d  = cnt_q - RED_CNT_W'(1);
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign stat_o.busy = (state_q == U_RED);
  assign stat_o.done = done_q;
  assign result_o    = rem_q;

endmodule

>>> sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Binary square-and-multiply of base^exponent mod modulus on one shared
// modular multiply unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: base_i and
//   exponent_i. Output channel (out_valid_o / out_stall_i) returns one word,
//   power_mod_o, per input word. A word moves on a rising edge with valid
//   high and stall low.
//   The modulus must be written through cfg_we_i / cfg_data_i only while the
//   block is idle; the block does not enforce this. Reset loads 2^31-1.
//   Only the low EXP_BITS exponent bits count. A zero exponent returns 1;
//   a modulus below two returns 0 for any nonzero exponent.
//   Each modular multiply runs as one registered product, then the
//   bit-serial remainder over the 62-bit product. A word needs
//   1 + EXP_BITS + ones(exponent) of them: the base reduction, one squaring
//   per exponent bit and one multiply per set bit. The result then waits in
//   S_OUT until the output register is free. Zero exponent or small modulus
//   words go straight to S_OUT without using the unit.
//   in_stall_o is high while a word is in work; one word at a time.
//   The result sits in an output register: the next word is accepted while
//   it waits, and a stalled result holds until taken. Reset clears all
//   control state; the output channel comes up empty.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mexp_pkg::BASE_W-1:0]   base_i,
  input  logic [mexp_pkg::EXP_IN_W-1:0] exponent_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mexp_pkg::MOD_W-1:0]    power_mod_o,
  input  logic                          cfg_we_i,
  input  logic [mexp_pkg::MOD_W-1:0]    cfg_data_i
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BASE = 5'b00010,   // base reduction in the unit
    S_SQR  = 5'b00100,   // r * r in the unit
    S_MUL  = 5'b01000,   // r * b in the unit
    S_OUT  = 5'b10000    // result waits for the output register
  } state_e;

  state_e              state_q, state_d;
  logic [MOD_W-1:0]    mod_q;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [CNT_W-1:0]    bit_q, bit_d;
  logic [MOD_W-1:0]    r_q, r_d;
  logic [MOD_W-1:0]    b_q, b_d;
  logic                out_valid_q, out_valid_d;
  logic [MOD_W-1:0]    out_q, out_d;

  mexp_req_t           req;
  mexp_stat_t          stat;
  logic [MOD_W-1:0]    op_a, op_b;
  logic [MOD_W-1:0]    unit_res;

  // exponent limited to EXP_BITS, zero-filled above the port width
  logic [EXP_BITS+EXP_IN_W-1:0] exp_ext;
  logic [EXP_BITS-1:0]          exp_in;
  logic                         out_free;
  logic                         in_acc;

  assign exp_ext  = {{EXP_BITS{1'b0}}, exponent_i};
  assign exp_in   = exp_ext[EXP_BITS-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

  mexp_mulred u_mulred (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .a_i      (op_a),
    .b_i      (op_b),
    .x_i      (base_i),
    .mod_i    (mod_q),
    .stat_o   (stat),
    .result_o (unit_res)
  );

  always_comb begin
    state_d     = state_q;
    exp_d       = exp_q;
    bit_d       = bit_q;
    r_d         = r_q;
    b_d         = b_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req.start   = 1'b0;
    req.op      = OP_MUL;
    op_a        = unit_res;
    op_b        = unit_res;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          exp_d = exp_in;
          bit_d = CNT_W'(EXP_BITS - 1);
          if (exp_in == '0) begin
            r_d     = MOD_W'(1);
            state_d = S_OUT;
          end else if (mod_q < MOD_W'(2)) begin
            r_d     = '0;
            state_d = S_OUT;
          end else begin
            r_d       = MOD_W'(1);
            req.start = 1'b1;
            req.op    = OP_RED;
            state_d   = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (stat.done) begin
          b_d       = unit_res;
          req.start = 1'b1;
          op_a      = r_q;
          op_b      = r_q;
          state_d   = S_SQR;
        end
      end
      S_SQR, S_MUL: begin
        if (stat.done) begin
          r_d = unit_res;
          if (state_q == S_SQR && exp_q[EXP_BITS-1]) begin
            req.start = 1'b1;
            op_b      = b_q;
            state_d   = S_MUL;
          end else if (bit_q == '0) begin
            state_d = S_OUT;
          end else begin
            // next exponent bit: square again
            bit_d     = bit_q - CNT_W'(1);
            exp_d     = exp_q << 1;
            req.start = 1'b1;
            state_d   = S_SQR;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = r_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= MOD_RESET;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_q       <= bit_d;
      if (cfg_we_i) begin
        mod_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    r_q   <= r_d;
    b_q   <= b_d;
    out_q <= out_d;
  end

endmodule
